// ----- rtl/prs_pkg.sv -----
// Package for the periodic task release scheduler.
// Holds the shared widths, register indexes, state and handshake types, and the
// function that builds the service order. No dependencies.
package prs_pkg;

  localparam int unsigned NUM_TASKS = 4;
  localparam int unsigned TASK_W    = 2;
  localparam int unsigned SLOT_W    = $clog2(NUM_TASKS);
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned STEP_W    = $clog2(CNT_W);

  localparam logic [CNT_W-1:0] MAX_COUNT_RST = CNT_W'(1000);
  localparam logic [CNT_W-1:0] COUNT_RST     = CNT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD    = 2'd0,
    REG_PRIORITY  = 2'd1,
    REG_MAX_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_RECORD,
    ST_EMIT,
    ST_ADVANCE
  } prs_state_e;

  typedef logic [TASK_W-1:0]                  task_id_t;
  typedef logic [SLOT_W-1:0]                  slot_t;
  typedef task_id_t [NUM_TASKS-1:0]           order_t;
  typedef logic [NUM_TASKS-1:0][BYTE_W-1:0]   byte_table_t;

  typedef struct packed {
    logic load_div;
    logic div_step;
    logic record;
    logic emit;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic slot_last;
    logic out_free;
  } status_t;

  // Each task's rank is the number of tasks that precede it: a smaller priority,
  // or an equal priority with a lower index.
  function automatic order_t build_order(input byte_table_t prio);
    order_t      order;
    logic [SLOT_W:0] rank;
    order = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      rank = '0;
      for (int j = 0; j < NUM_TASKS; j++) begin
        if ((prio[j] < prio[t]) || ((prio[j] == prio[t]) && (j < t))) begin
          rank = rank + 1'b1;
        end
      end
      order[rank[SLOT_W-1:0]] = TASK_W'(t);
    end
    return order;
  endfunction

endpackage

// ----- rtl/prs_if.sv -----
// Handshake interfaces for the tick input and the released task output.
// Depends on prs_pkg.
interface prs_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface prs_result_if;
  import prs_pkg::*;
  logic     valid;
  logic     ready;
  task_id_t task_id;
  logic     last;
  modport source (output valid, output task_id, output last, input ready);
  modport sink (input valid, input task_id, input last, output ready);
endinterface

// ----- rtl/prs_datapath.sv -----
// Datapath: configuration registers, tick counter, bit-serial modulo unit,
// ready flags per service slot and the output word register. Depends on prs_pkg.
module prs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [prs_pkg::CFG_W-1:0]           cfg_data_i,
  input  prs_pkg::cmd_t                       cmd_i,
  output prs_pkg::status_t                    status_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output prs_pkg::task_id_t                   out_task_id_o,
  output logic                                out_last_o
);
  import prs_pkg::*;

  byte_table_t          period_q;
  order_t               order_q;
  logic [CNT_W-1:0]     max_count_q;
  logic [CNT_W-1:0]     tick_count_q;
  logic [CNT_W-1:0]     dvd_q;
  logic [BYTE_W-1:0]    rem_q;
  logic [STEP_W-1:0]    step_q;
  slot_t                slot_q;
  logic [NUM_TASKS-1:0] ready_q;
  logic                 out_valid_q;
  task_id_t             out_task_q;
  logic                 out_last_q;

  task_id_t             cur_task;
  logic [BYTE_W-1:0]    cur_period;
  logic [BYTE_W:0]      rem_shift;
  logic [BYTE_W:0]      rem_sub;
  logic [BYTE_W-1:0]    rem_d;
  logic                 hit;
  logic                 later_ready;
  logic                 slot_last;
  logic                 out_free;
  slot_t                slot_inc;

  assign cur_task   = order_q[slot_q];
  assign cur_period = period_q[cur_task];
  assign rem_shift  = {rem_q, dvd_q[CNT_W-1]};
  assign rem_sub    = rem_shift - {1'b0, cur_period};
  assign rem_d      = (rem_shift >= {1'b0, cur_period}) ? rem_sub[BYTE_W-1:0]
                                                         : rem_shift[BYTE_W-1:0];
  assign hit        = (cur_period != '0) && (rem_q == '0);
  assign slot_last  = (slot_q == SLOT_W'(NUM_TASKS - 1));
  assign slot_inc   = slot_last ? '0 : slot_q + 1'b1;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    later_ready = 1'b0;
    for (int s = 0; s < NUM_TASKS; s++) begin
      if ((SLOT_W'(s) > slot_q) && ready_q[s]) begin
        later_ready = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= '0;
      order_q     <= build_order('0);
      max_count_q <= MAX_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD:    period_q    <= cfg_data_i;
        REG_PRIORITY:  order_q     <= build_order(cfg_data_i);
        REG_MAX_COUNT: max_count_q <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= COUNT_RST;
    end else if (cmd_i.advance) begin
      if (tick_count_q < max_count_q) begin
        tick_count_q <= tick_count_q + 1'b1;
      end else begin
        tick_count_q <= COUNT_RST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      slot_q <= '0;
    end else if (cmd_i.load_div) begin
      step_q <= '0;
      slot_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end else if (cmd_i.record) begin
      step_q <= '0;
      slot_q <= slot_inc;
    end else if (cmd_i.emit && out_free) begin
      slot_q <= slot_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div || (cmd_i.record && !slot_last)) begin
      dvd_q <= tick_count_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.record) begin
      ready_q[slot_q] <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit && out_free && ready_q[slot_q]) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && out_free && ready_q[slot_q]) begin
      out_task_q <= cur_task;
      out_last_q <= !later_ready;
    end
  end

  assign status_o.div_last  = (step_q == STEP_W'(CNT_W - 1));
  assign status_o.slot_last = slot_last;
  assign status_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign out_task_id_o = out_task_q;
  assign out_last_o    = out_last_q;

endmodule

// ----- rtl/prs_controller.sv -----
// Controller state machine that sequences one tick: modulo per slot, ready
// capture, ordered emission and counter advance. Depends on prs_pkg.
module prs_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_tick_i,
  output logic             in_ready_o,
  input  prs_pkg::status_t status_i,
  output prs_pkg::cmd_t    cmd_o
);
  import prs_pkg::*;

  prs_state_e state_q;
  prs_state_e state_d;
  logic       start;

  assign start = in_valid_i && in_tick_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status_i.div_last) state_d = ST_RECORD;
      end
      ST_RECORD: begin
        state_d = status_i.slot_last ? ST_EMIT : ST_DIVIDE;
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.slot_last) state_d = ST_ADVANCE;
      end
      ST_ADVANCE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.load_div = start;
      end
      ST_DIVIDE:  cmd_o.div_step = 1'b1;
      ST_RECORD:  cmd_o.record   = 1'b1;
      ST_EMIT:    cmd_o.emit     = 1'b1;
      ST_ADVANCE: cmd_o.advance  = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/periodic_task_release_scheduler.sv -----
// A tick is taken only in the idle state; no new tick is accepted until the last one is done.
// Each tick runs four 16-step modulo passes, then an emit pass that output stalls can hold.
// Each task passes through the shared bit-serial modulo unit; then slots are emitted in order.
// Reset: periods and priorities zero, maximum count 1000, tick count one, no clearing pass.
// Top level: joins controller and datapath to the tick and result interfaces. Uses prs_pkg.
module periodic_task_release_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prs_tick_if.sink                      tick_i,
  prs_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [prs_pkg::CFG_W-1:0]     cfg_data_i
);
  import prs_pkg::*;

  cmd_t    cmd;
  status_t status;

  prs_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tick_i.valid),
    .in_tick_i  (tick_i.tick),
    .in_ready_o (tick_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prs_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (result_o.ready),
    .out_valid_o   (result_o.valid),
    .out_task_id_o (result_o.task_id),
    .out_last_o    (result_o.last)
  );

endmodule

// ----- rtl/prs_checker.sv -----
// Port-level checker for the scheduler, bound to the top level.
// Depends on prs_pkg and the top level's interface ports.
module prs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              in_tick_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input prs_pkg::task_id_t out_task_id_i,
  input logic              out_last_i
);
  import prs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_task_id_i) && $stable(out_last_i))
    else $error("Result word changed while stalled.");

  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_tick_i |=> !in_ready_i)
    else $error("Input still ready after a tick was taken.");

  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i)
    else $error("Result word appeared while the block was idle.");

endmodule

bind periodic_task_release_scheduler prs_checker u_prs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (tick_i.valid),
  .in_ready_i    (tick_i.ready),
  .in_tick_i     (tick_i.tick),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_task_id_i (result_o.task_id),
  .out_last_i    (result_o.last)
);
